[hw/rtl/ltsw_pkg.sv]
// Shared types, constants and helper functions of the whole-word text search block.
`timescale 1ns / 1ps
`default_nettype none

package ltsw_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int MAX_COLUMNS = 65536;
  localparam int MAX_LINES   = 65536;

  localparam logic [15:0] COL_LIMIT  = 16'(MAX_COLUMNS - 1);
  localparam logic [15:0] LINE_LIMIT = 16'(MAX_LINES - 1);

  localparam logic [7:0] UNDERSCORE = 8'h5F;

  // Depths of the item queue behind the input and of the result queue.
  localparam int ITEM_QUEUE_DEPTH   = 2;
  localparam int RESULT_QUEUE_DEPTH = 4;

  // Request codes on the input channel.
  localparam logic [1:0] REQ_TEXT = 2'd0;
  localparam logic [1:0] REQ_EOL  = 2'd1;
  localparam logic [1:0] REQ_EOT  = 2'd2;

  // Bits of the search mode register.
  localparam int MODE_EXACT = 0;
  localparam int MODE_WHOLE = 1;
  localparam int MODE_SCOPE = 2;

  // Result kinds.
  localparam logic RESULT_MATCH = 1'b0;
  localparam logic RESULT_TOTAL = 1'b1;

  typedef enum logic [3:0] {
    REG_PATTERN_LOW        = 4'd0,
    REG_PATTERN_HIGH       = 4'd1,
    REG_PATTERN_LENGTH     = 4'd2,
    REG_SEARCH_MODE        = 4'd3,
    REG_SCOPE_FIRST_LINE   = 4'd4,
    REG_SCOPE_FIRST_COLUMN = 4'd5,
    REG_SCOPE_LAST_LINE    = 4'd6,
    REG_SCOPE_LAST_COLUMN  = 4'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_EOL  = 2'd1,
    KIND_EOT  = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  char_code;
    logic        is_word;
  } item_t;

  typedef struct packed {
    logic [127:0] pattern;
    logic [4:0]   pattern_length;
    logic [2:0]   search_mode;
    logic [15:0]  scope_first_line;
    logic [15:0]  scope_first_column;
    logic [15:0]  scope_last_line;
    logic [15:0]  scope_last_column;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [31:0] total;
    logic        last;
  } result_t;

  // Up to two results written into the result queue in one cycle, a before b.
  typedef struct packed {
    logic    a_valid;
    result_t a;
    logic    b_valid;
    result_t b;
  } rwrite_t;

  typedef struct packed {
    logic        accept;
    logic [15:0] next_allowed;
    logic [31:0] count;
  } decide_t;

  function automatic logic word_byte(input logic [7:0] b);
    return (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) || (b == UNDERSCORE);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] b, input logic en);
    return (en && (b inside {[8'h41:8'h5A]})) ? b + 8'h20 : b;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ltsw_front.sv]
// Input side: classifies incoming words and holds them in a short item queue.
`timescale 1ns / 1ps
`default_nettype none

module ltsw_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     req_type,
  input  logic [7:0]     char_code,
  output logic           item_valid,
  output ltsw_pkg::item_t item,
  input  logic           item_pop
);
  import ltsw_pkg::*;

  item_t      q [0:ITEM_QUEUE_DEPTH-1];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  item_t      in_item;
  logic       keep;
  logic       wr;

  // Unused request codes are accepted and dropped here.
  always_comb begin
    in_item.char_code = char_code;
    in_item.is_word   = word_byte(char_code);
    in_item.kind      = KIND_TEXT;
    keep              = 1'b1;
    case (req_type)
      REQ_TEXT: in_item.kind = KIND_TEXT;
      REQ_EOL:  in_item.kind = KIND_EOL;
      REQ_EOT:  in_item.kind = KIND_EOT;
      default:  keep = 1'b0;
    endcase
  end

  assign full       = (count == 2'(ITEM_QUEUE_DEPTH));
  assign item_valid = (count != 2'd0);
  assign item       = q[rptr];
  assign wr         = push && !full && keep;

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (item_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(wr) - 2'(item_pop);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ltsw_scan.sv]
// Scan engine: byte window compare, candidate decisions, line and column tracking.
`timescale 1ns / 1ps
`default_nettype none

module ltsw_scan (
  input  logic              clk,
  input  logic              rst,
  input  ltsw_pkg::cfg_t    cfg,
  input  logic              item_valid,
  input  ltsw_pkg::item_t   item,
  output logic              item_pop,
  input  logic              room,
  output ltsw_pkg::rwrite_t rw
);
  import ltsw_pkg::*;

  logic [15:0] line_counter, line_counter_next;
  logic [15:0] column_counter, column_counter_next;
  logic [15:0] next_allowed, next_allowed_next;
  logic        pending_valid, pending_valid_next;
  logic [15:0] pending_column, pending_column_next;
  logic        pending_left_ok, pending_left_ok_next;
  logic [31:0] accepted_count, accepted_count_next;

  logic [7:0]  win_byte [0:PATTERN_MAX-1];
  logic [PATTERN_MAX:0] win_word;
  logic [7:0]  wn_byte [0:PATTERN_MAX-1];
  logic [PATTERN_MAX:0] wn_word;

  logic [4:0]  len_eff;
  logic [15:0] col_plus;
  logic [15:0] s;
  logic        reach;
  logic        take;
  logic        shift;
  logic        fold_en;
  logic [3:0]  pat_idx [0:PATTERN_MAX-1];
  logic [PATTERN_MAX-1:0] eq;
  logic        hit;
  logic        cand;
  logic        pend_ok;
  logic [15:0] na_mid;
  logic [31:0] cnt_mid;
  decide_t     dec_p;
  decide_t     dec_i;

  function automatic decide_t decide(input logic [15:0] st, input logic ok,
                                     input logic [4:0] len, input logic [15:0] line,
                                     input cfg_t c, input logic [31:0] cnt);
    decide_t     d;
    logic [16:0] st_end;
    logic        scope_ok;
    st_end   = {1'b0, st} + 17'(len);
    scope_ok = 1'b1;
    if (c.search_mode[MODE_SCOPE]) begin
      if (line < c.scope_first_line || line > c.scope_last_line) begin
        scope_ok = 1'b0;
      end
      if (line == c.scope_first_line && st < c.scope_first_column) begin
        scope_ok = 1'b0;
      end
      if (line == c.scope_last_line && st_end > {1'b0, c.scope_last_column}) begin
        scope_ok = 1'b0;
      end
    end
    d.accept       = ok && scope_ok;
    d.next_allowed = ok ? st_end[15:0] : st + 16'd1;
    d.count        = (d.accept && cnt != '1) ? cnt + 32'd1 : cnt;
    return d;
  endfunction

  function automatic result_t match_result(input logic [15:0] line, input logic [15:0] col,
                                           input logic [31:0] total);
    result_t r;
    r.kind   = RESULT_MATCH;
    r.line   = line;
    r.column = col;
    r.total  = total;
    r.last   = 1'b0;
    return r;
  endfunction

  assign take     = item_valid && room;
  assign item_pop = take;
  assign shift    = take && (item.kind == KIND_TEXT) && (column_counter != COL_LIMIT);
  assign len_eff  = (cfg.pattern_length > 5'(PATTERN_MAX)) ? 5'(PATTERN_MAX)
                                                           : cfg.pattern_length;
  assign fold_en  = !cfg.search_mode[MODE_EXACT];
  assign col_plus = column_counter + 16'd1;
  assign reach    = (len_eff != 5'd0) && (16'(len_eff) <= col_plus);
  assign s        = col_plus - 16'(len_eff);

  // Window as it stands once the new byte is shifted in; entry 0 is the newest byte.
  always_comb begin
    wn_byte[0] = item.char_code;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      wn_byte[j] = win_byte[j-1];
    end
    wn_word = {win_word[PATTERN_MAX-1:0], item.is_word};
  end

  // Window entry j lines up with pattern byte len-1-j.
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pat_idx[j] = 4'(len_eff - 5'(j) - 5'd1);
      eq[j] = (5'(j) >= len_eff) ||
              (fold(wn_byte[j], fold_en) ==
               fold(cfg.pattern[{pat_idx[j], 3'b000} +: 8], fold_en));
    end
  end

  assign hit  = &eq;
  assign cand = reach && hit && (s >= na_mid);

  // A held candidate sees the new byte as its right neighbor; a line end is a non-word.
  assign pend_ok = pending_left_ok && !((item.kind == KIND_TEXT) && item.is_word);
  assign dec_p   = decide(pending_column, pend_ok, len_eff, line_counter, cfg, accepted_count);
  assign na_mid  = pending_valid ? dec_p.next_allowed : next_allowed;
  assign cnt_mid = pending_valid ? dec_p.count : accepted_count;
  assign dec_i   = decide(s, 1'b1, len_eff, line_counter, cfg, cnt_mid);

  always_comb begin
    line_counter_next    = line_counter;
    column_counter_next  = column_counter;
    next_allowed_next    = next_allowed;
    pending_valid_next   = pending_valid;
    pending_column_next  = pending_column;
    pending_left_ok_next = pending_left_ok;
    accepted_count_next  = accepted_count;
    rw                   = '0;

    if (take) begin
      // The held candidate is settled first when the item is shifted in or is not a text byte.
      if (pending_valid && (shift || item.kind != KIND_TEXT)) begin
        pending_valid_next  = 1'b0;
        next_allowed_next   = dec_p.next_allowed;
        accepted_count_next = dec_p.count;
        rw.a_valid          = dec_p.accept;
        rw.a                = match_result(line_counter, pending_column, dec_p.count);
      end
      case (item.kind)
        KIND_TEXT: begin
          if (shift) begin
            column_counter_next = col_plus;
            if (cand) begin
              if (cfg.search_mode[MODE_WHOLE]) begin
                pending_valid_next   = 1'b1;
                pending_column_next  = s;
                pending_left_ok_next = (s == 16'd0) || !wn_word[len_eff];
              end else begin
                next_allowed_next   = dec_i.next_allowed;
                accepted_count_next = dec_i.count;
                rw.b_valid          = dec_i.accept;
                rw.b                = match_result(line_counter, s, dec_i.count);
              end
            end
          end
        end
        KIND_EOL: begin
          column_counter_next = 16'd0;
          next_allowed_next   = 16'd0;
          pending_valid_next  = 1'b0;
          if (line_counter != LINE_LIMIT) begin
            line_counter_next = line_counter + 16'd1;
          end
        end
        KIND_EOT: begin
          rw.b_valid          = 1'b1;
          rw.b.kind           = RESULT_TOTAL;
          rw.b.line           = 16'd0;
          rw.b.column         = 16'd0;
          rw.b.total          = cnt_mid;
          column_counter_next = 16'd0;
          next_allowed_next   = 16'd0;
          pending_valid_next  = 1'b0;
          line_counter_next   = 16'd0;
          accepted_count_next = 32'd0;
        end
        default: begin
        end
      endcase
    end

    rw.a.last = !rw.b_valid;
    rw.b.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      win_byte <= wn_byte;
      win_word <= wn_word;
    end
    pending_column  <= pending_column_next;
    pending_left_ok <= pending_left_ok_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_counter   <= 16'd0;
      column_counter <= 16'd0;
      next_allowed   <= 16'd0;
      pending_valid  <= 1'b0;
      accepted_count <= 32'd0;
    end else begin
      line_counter   <= line_counter_next;
      column_counter <= column_counter_next;
      next_allowed   <= next_allowed_next;
      pending_valid  <= pending_valid_next;
      accepted_count <= accepted_count_next;
    end
  end

  a_pending_behind_cursor: assert property (@(posedge clk) disable iff (rst)
    pending_valid |-> (pending_column < column_counter))
    else $error("held candidate does not start before the current column");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    (take && item.kind == KIND_EOT) |=> (accepted_count == 32'd0 && line_counter == 16'd0))
    else $error("end of text did not clear count and line");

  a_result_needs_item: assert property (@(posedge clk) disable iff (rst)
    (rw.a_valid || rw.b_valid) |-> take)
    else $error("result produced without an item taken");

endmodule

`default_nettype wire

[hw/rtl/ltsw_rfifo.sv]
// Result queue: takes up to two results a cycle, hands out one a cycle.
`timescale 1ns / 1ps
`default_nettype none

module ltsw_rfifo (
  input  logic              clk,
  input  logic              rst,
  input  ltsw_pkg::rwrite_t rw,
  output logic              room,
  output logic              empty,
  input  logic              pop,
  output ltsw_pkg::result_t rd
);
  import ltsw_pkg::*;

  result_t    mem [0:RESULT_QUEUE_DEPTH-1];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;
  logic       pop_ok;
  logic [1:0] n_wr;

  assign empty  = (count == 3'd0);
  assign room   = (count <= 3'(RESULT_QUEUE_DEPTH - 2));
  assign pop_ok = pop && !empty;
  assign n_wr   = 2'(rw.a_valid) + 2'(rw.b_valid);
  assign rd     = mem[rptr];

  always_ff @(posedge clk) begin
    if (rw.a_valid) begin
      mem[wptr] <= rw.a;
    end
    if (rw.b_valid) begin
      mem[wptr + 2'(rw.a_valid)] <= rw.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      wptr  <= wptr + n_wr;
      rptr  <= rptr + 2'(pop_ok);
      count <= count + 3'(n_wr) - 3'(pop_ok);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (rw.a_valid || rw.b_valid) |-> (count <= 3'(RESULT_QUEUE_DEPTH - 2)))
    else $error("result queue written without room for two words");

endmodule

`default_nettype wire

[hw/rtl/literal_text_search_whole_word_unit.sv]
// Top level of the whole-word literal text search block with its configuration registers.
// Usage:
//   Input channel: a word (req_type, char_code) is taken at a clock edge where push is
//   high and full is low. req_type selects a text byte, an end of line or an end of text;
//   code 3 is taken and dropped. A short item queue sits behind the input.
//   Result channel: while empty is low the oldest result word is on the result ports;
//   it leaves at an edge where pop is high. One input word gives zero, one or two result
//   words; last_of_run marks the final one of a run. An end of text always gives a total.
//   Configuration: cfg_index and cfg_data are written when cfg_valid and cfg_ready are
//   both high; cfg_ready is always high. Write only while the block is idle.
//   A taken word passes through the item queue and the scan engine into the result queue.
//   Throughput: one input word per cycle while full is low; the scan engine handles one
//   word a cycle and moves it on when the result queue has room for two words, so a
//   stalled receiver fills the result queue, then the item queue, and then raises full.
//   Reset (rst, synchronous) empties both queues, clears the scan state and count and
//   returns every configuration register to zero.
`timescale 1ns / 1ps
`default_nettype none

module literal_text_search_whole_word_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [7:0]  char_code,
  output logic        empty,
  input  logic        pop,
  output logic        result_kind,
  output logic [15:0] match_line,
  output logic [15:0] match_column,
  output logic [31:0] match_total,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ltsw_pkg::*;

  logic [63:0] pattern_low;
  logic [63:0] pattern_high;
  logic [4:0]  pattern_length;
  logic [2:0]  search_mode;
  logic [15:0] scope_first_line;
  logic [15:0] scope_first_column;
  logic [15:0] scope_last_line;
  logic [15:0] scope_last_column;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    item_pop;
  logic    room;
  rwrite_t rw;
  result_t rd;

  // Registers never back-pressure the write channel.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low        <= 64'd0;
      pattern_high       <= 64'd0;
      pattern_length     <= 5'd0;
      search_mode        <= 3'd0;
      scope_first_line   <= 16'd0;
      scope_first_column <= 16'd0;
      scope_last_line    <= 16'd0;
      scope_last_column  <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_LOW:        pattern_low        <= cfg_data;
        REG_PATTERN_HIGH:       pattern_high       <= cfg_data;
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[4:0];
        REG_SEARCH_MODE:        search_mode        <= cfg_data[2:0];
        REG_SCOPE_FIRST_LINE:   scope_first_line   <= cfg_data[15:0];
        REG_SCOPE_FIRST_COLUMN: scope_first_column <= cfg_data[15:0];
        REG_SCOPE_LAST_LINE:    scope_last_line    <= cfg_data[15:0];
        REG_SCOPE_LAST_COLUMN:  scope_last_column  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Pattern byte k sits in bits 8k+7:8k of the combined pattern word.
  assign cfg.pattern            = {pattern_high, pattern_low};
  assign cfg.pattern_length     = pattern_length;
  assign cfg.search_mode        = search_mode;
  assign cfg.scope_first_line   = scope_first_line;
  assign cfg.scope_first_column = scope_first_column;
  assign cfg.scope_last_line    = scope_last_line;
  assign cfg.scope_last_column  = scope_last_column;

  ltsw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .char_code  (char_code),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  ltsw_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .room       (room),
    .rw         (rw)
  );

  ltsw_rfifo u_rfifo (
    .clk   (clk),
    .rst   (rst),
    .rw    (rw),
    .room  (room),
    .empty (empty),
    .pop   (pop),
    .rd    (rd)
  );

  assign result_kind  = rd.kind;
  assign match_line   = rd.line;
  assign match_column = rd.column;
  assign match_total  = rd.total;
  assign last_of_run  = rd.last;

endmodule

`default_nettype wire
